/* rtl/lps_pkg.sv */
// Shared types and constants for the line pixel stepper.
package lps_pkg;

    localparam int COORD_BITS = 6;
    // The error term stays within -delta_y .. delta_x, with headroom for one update.
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int E2_BITS    = ERR_BITS + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
    } t_req;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic                  last_pixel;
    } t_pix;

    typedef struct packed {
        logic [COORD_BITS-1:0]      cur_x;
        logic [COORD_BITS-1:0]      cur_y;
        logic [COORD_BITS-1:0]      end_x;
        logic [COORD_BITS-1:0]      end_y;
        logic [COORD_BITS-1:0]      delta_x;
        logic [COORD_BITS-1:0]      delta_y;
        logic                       x_down;
        logic                       y_down;
        logic signed [ERR_BITS-1:0] err;
    } t_job;

    typedef struct packed {
        logic                 valid;
        logic                 full;
        logic [QCNT_BITS-1:0] count;
    } t_qstat;

endpackage

/* rtl/line_pixel_stepper.sv */
// Top level of the Bresenham line pixel stepper.
// The first pixel word passes the queue, the job register and the output register in turn.
// Throughput: one pixel per cycle while the sink is ready; the stepper returns to idle
// between lines to take the next job; two requests can wait in the queue.
// Reset is synchronous and active low; it empties the queue and the output register.
module line_pixel_stepper (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lps_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output lps_pkg::t_pix o_pix
);

    logic            push;
    logic            pop;
    logic            back_idle;
    lps_pkg::t_job   front_job;
    lps_pkg::t_job   queue_job;
    lps_pkg::t_qstat qstat;

    lps_front u_front (
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_push  (push),
        .i_full  (qstat.full),
        .o_job   (front_job)
    );

    lps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_stat  (qstat)
    );

    lps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (qstat.valid),
        .i_job       (queue_job),
        .o_pop       (pop),
        .o_idle      (back_idle),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pix       (o_pix)
    );

`ifndef SYNTH
    a_qcount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.count <= lps_pkg::QCNT_BITS'(lps_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_accept_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> qstat.valid)
        else $error("accepted request missing from queue");

    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_idle |-> (!o_valid || o_pix.last_pixel))
        else $error("stepper idle while a line is unfinished");
`endif

endmodule

/* rtl/lps_front.sv */
// Request classifier: deltas, step directions and initial error term.
module lps_front (
    input  logic          i_valid,
    output logic          o_ready,
    input  lps_pkg::t_req i_req,
    output logic          o_push,
    input  logic          i_full,
    output lps_pkg::t_job o_job
);

    logic [lps_pkg::COORD_BITS-1:0] dx;
    logic [lps_pkg::COORD_BITS-1:0] dy;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        if (i_req.end_x > i_req.start_x) begin
            dx = i_req.end_x - i_req.start_x;
        end else begin
            dx = i_req.start_x - i_req.end_x;
        end
        if (i_req.end_y > i_req.start_y) begin
            dy = i_req.end_y - i_req.start_y;
        end else begin
            dy = i_req.start_y - i_req.end_y;
        end
        o_job.cur_x   = i_req.start_x;
        o_job.cur_y   = i_req.start_y;
        o_job.end_x   = i_req.end_x;
        o_job.end_y   = i_req.end_y;
        o_job.delta_x = dx;
        o_job.delta_y = dy;
        // A zero delta still marks the axis as stepping down; no step is taken there.
        o_job.x_down  = !(i_req.start_x < i_req.end_x);
        o_job.y_down  = !(i_req.start_y < i_req.end_y);
        o_job.err     = $signed({2'b00, dx}) - $signed({2'b00, dy});
    end

endmodule

/* rtl/lps_queue.sv */
// Two-entry queue of classified line jobs between front and back.
module lps_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lps_pkg::t_job   i_job,
    input  logic            i_pop,
    output lps_pkg::t_job   o_job,
    output lps_pkg::t_qstat o_stat
);

    lps_pkg::t_job                 r_mem [lps_pkg::QUEUE_DEPTH];
    logic [lps_pkg::QPTR_BITS-1:0] r_wptr;
    logic [lps_pkg::QPTR_BITS-1:0] r_rptr;
    logic [lps_pkg::QCNT_BITS-1:0] r_cnt;
    logic                          do_push;
    logic                          do_pop;

    assign o_stat.valid = (r_cnt != '0);
    assign o_stat.full  = (r_cnt == lps_pkg::QCNT_BITS'(lps_pkg::QUEUE_DEPTH));
    assign o_stat.count = r_cnt;
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && o_stat.valid;
    assign o_job        = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/lps_back.sv */
// Bresenham stepper: walks one job and emits one pixel word per cycle while the sink is ready.
module lps_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  lps_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_idle,
    output logic          o_valid,
    input  logic          i_ready,
    output lps_pkg::t_pix o_pix
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state        r_state;
    t_state        n_state;
    lps_pkg::t_job r_job;
    lps_pkg::t_job n_job;
    logic          r_valid;
    logic          n_valid;
    lps_pkg::t_pix r_pix;
    lps_pkg::t_pix n_pix;

    logic                              emit;
    logic                              at_end;
    logic                              step_x;
    logic                              step_y;
    logic signed [lps_pkg::E2_BITS-1:0] e2;
    logic signed [lps_pkg::E2_BITS-1:0] sdx;
    logic signed [lps_pkg::E2_BITS-1:0] sdy;
    logic signed [lps_pkg::E2_BITS-1:0] err_ext;
    logic signed [lps_pkg::E2_BITS-1:0] err_nxt;

    assign o_pop   = (r_state == ST_IDLE) && i_job_valid;
    assign o_idle  = (r_state == ST_IDLE);
    assign o_valid = r_valid;
    assign o_pix   = r_pix;
    assign emit    = (r_state == ST_RUN) && (!r_valid || i_ready);
    assign at_end  = (r_job.cur_x == r_job.end_x) && (r_job.cur_y == r_job.end_y);

    always_comb begin
        sdx     = $signed({{(lps_pkg::E2_BITS-lps_pkg::COORD_BITS){1'b0}}, r_job.delta_x});
        sdy     = $signed({{(lps_pkg::E2_BITS-lps_pkg::COORD_BITS){1'b0}}, r_job.delta_y});
        err_ext = lps_pkg::E2_BITS'(r_job.err);
        e2      = $signed({r_job.err, 1'b0});
        step_x  = (e2 > -sdy);
        step_y  = (e2 < sdx);
        err_nxt = err_ext;
        if (step_x) begin
            err_nxt = err_nxt - sdy;
        end
        if (step_y) begin
            err_nxt = err_nxt + sdx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_valid = r_valid;
        n_pix   = r_pix;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_job   = i_job;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (emit) begin
                    n_valid          = 1'b1;
                    n_pix.pixel_x    = r_job.cur_x;
                    n_pix.pixel_y    = r_job.cur_y;
                    n_pix.last_pixel = at_end;
                    if (at_end) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_job.err = err_nxt[lps_pkg::ERR_BITS-1:0];
                        if (step_x) begin
                            n_job.cur_x = r_job.x_down
                                ? r_job.cur_x - lps_pkg::COORD_BITS'(1)
                                : r_job.cur_x + lps_pkg::COORD_BITS'(1);
                        end
                        if (step_y) begin
                            n_job.cur_y = r_job.y_down
                                ? r_job.cur_y - lps_pkg::COORD_BITS'(1)
                                : r_job.cur_y + lps_pkg::COORD_BITS'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_pix <= n_pix;
    end

endmodule

/* sim/tb_line_pixel_stepper.sv */
// Self-checking testbench for the Bresenham line pixel stepper.
`timescale 1ns / 1ps

module tb_line_pixel_stepper;

    localparam int COORD_MAX   = (1 << lps_pkg::COORD_BITS) - 1;
    localparam int RANDOM_BLKS = 5;
    localparam int BLK_LINES   = 25;
    localparam int STALL_LIMIT = 500;
    localparam int DRAIN_WAIT  = 16;

    typedef struct {
        lps_pkg::t_req req;
        bit            typed;
        lps_pkg::t_pix dot;
    } t_line_row;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          i_ready = 1'b0;
    lps_pkg::t_req i_req   = '0;
    logic          o_ready;
    logic          o_valid;
    lps_pkg::t_pix o_pix;

    lps_pkg::t_pix pending_pixels[$];
    t_line_row     directed_lines[$];
    lps_pkg::t_pix want_pix;
    int            mismatches  = 0;
    int            idle_cycles = 0;
    bit            tx_burst    = 1'b0;
    bit            rx_burst    = 1'b0;
    bit            dot_typed   = 1'b0;
    lps_pkg::t_pix dot_pix     = '0;

    line_pixel_stepper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_pix   (o_pix)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Walks the line with the integer error term and queues every pixel it visits.
    task automatic trace_line(input lps_pkg::t_req req);
        int x, y, ex, ey, dx, dy, sx, sy, err, e2, n;
        bit at_end, done;
        lps_pkg::t_pix p;
        x  = req.start_x;
        y  = req.start_y;
        ex = req.end_x;
        ey = req.end_y;
        dx = (ex > x) ? ex - x : x - ex;
        dy = (ey > y) ? ey - y : y - ey;
        sx = (x < ex) ? 1 : -1;
        sy = (y < ey) ? 1 : -1;
        err  = dx - dy;
        n    = 0;
        done = 1'b0;
        while (!done) begin
            at_end       = (x == ex) && (y == ey);
            p.pixel_x    = x[lps_pkg::COORD_BITS-1:0];
            p.pixel_y    = y[lps_pkg::COORD_BITS-1:0];
            p.last_pixel = at_end;
            pending_pixels.push_back(p);
            n++;
            done = at_end || (n > COORD_MAX);
            if (!done) begin
                e2 = 2 * err;
                if (e2 > -dy) begin
                    err -= dy;
                    x   += sx;
                end
                if (e2 < dx) begin
                    err += dx;
                    y   += sy;
                end
            end
        end
    endtask

    task automatic report_field(input string name,
                                input logic [lps_pkg::COORD_BITS-1:0] want_v,
                                input logic [lps_pkg::COORD_BITS-1:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Both handshakes are sampled here, so checking and prediction keep one order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_pixels.size() == 0) begin
                    $display("%0t: unexpected pixel word x=%0d y=%0d last=%0b",
                             $time, o_pix.pixel_x, o_pix.pixel_y, o_pix.last_pixel);
                    mismatches++;
                end else begin
                    want_pix = pending_pixels.pop_front();
                    report_field("pixel_x", want_pix.pixel_x, o_pix.pixel_x);
                    report_field("pixel_y", want_pix.pixel_y, o_pix.pixel_y);
                    report_field("last_pixel",
                                 lps_pkg::COORD_BITS'(want_pix.last_pixel),
                                 lps_pkg::COORD_BITS'(o_pix.last_pixel));
                end
            end
            if (i_valid && o_ready) begin
                if (dot_typed)
                    pending_pixels.push_back(dot_pix);
                else
                    trace_line(i_req);
            end
        end
        if ((o_valid && i_ready) || (i_valid && o_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // The pixel sink stalls for a random time before taking each word, except in burst blocks.
    initial begin
        int stall;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    function automatic lps_pkg::t_req line_req(input int sx, input int sy,
                                               input int ex, input int ey);
        lps_pkg::t_req r;
        r.start_x = lps_pkg::COORD_BITS'(sx);
        r.start_y = lps_pkg::COORD_BITS'(sy);
        r.end_x   = lps_pkg::COORD_BITS'(ex);
        r.end_y   = lps_pkg::COORD_BITS'(ey);
        return r;
    endfunction

    task automatic add_line(input int sx, input int sy, input int ex, input int ey);
        t_line_row row;
        row.req   = line_req(sx, sy, ex, ey);
        row.typed = 1'b0;
        row.dot   = '0;
        directed_lines.push_back(row);
    endtask

    // A line whose ends coincide is a single pixel, marked last.
    task automatic add_dot(input int x, input int y);
        t_line_row row;
        row.req   = line_req(x, y, x, y);
        row.typed = 1'b1;
        row.dot.pixel_x    = lps_pkg::COORD_BITS'(x);
        row.dot.pixel_y    = lps_pkg::COORD_BITS'(y);
        row.dot.last_pixel = 1'b1;
        directed_lines.push_back(row);
    endtask

    function automatic logic [lps_pkg::COORD_BITS-1:0] fit_coord(input int v);
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return lps_pkg::COORD_BITS'(COORD_MAX);
        return v[lps_pkg::COORD_BITS-1:0];
    endfunction

    function automatic logic [lps_pkg::COORD_BITS-1:0] edge_coord();
        return lps_pkg::COORD_BITS'($urandom_range(0, 1) ? COORD_MAX : 0);
    endfunction

    function automatic lps_pkg::t_req random_req();
        lps_pkg::t_req r;
        bit [31:0] raw;
        int kind;
        raw  = $urandom;
        r    = raw[$bits(lps_pkg::t_req)-1:0];
        kind = $urandom_range(0, 9);
        if (kind == 5 || kind == 6) begin
            r.end_x = fit_coord(int'(r.start_x) + int'($urandom_range(0, 8)) - 4);
            r.end_y = fit_coord(int'(r.start_y) + int'($urandom_range(0, 8)) - 4);
        end else if (kind == 7) begin
            r.end_x = r.start_x;
            r.end_y = r.start_y;
        end else if (kind == 8) begin
            if ($urandom_range(0, 1))
                r.end_y = r.start_y;
            else
                r.end_x = r.start_x;
        end else if (kind == 9) begin
            r.start_x = edge_coord();
            r.start_y = edge_coord();
            r.end_x   = edge_coord();
            r.end_y   = edge_coord();
        end
        return r;
    endfunction

    // Holds the request word until the stepper takes it; called at a falling edge.
    task automatic send_line(input lps_pkg::t_req req, input bit typed,
                             input lps_pkg::t_pix dot);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req     <= req;
        dot_typed <= typed;
        dot_pix   <= dot;
        i_valid   <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    initial begin
        add_dot(0, 0);
        add_dot(63, 63);
        add_dot(0, 63);
        add_dot(21, 42);
        add_line(0, 0, 63, 63);
        add_line(63, 63, 0, 0);
        add_line(0, 0, 63, 0);
        add_line(63, 0, 0, 0);
        add_line(0, 0, 0, 63);
        add_line(0, 63, 0, 0);
        add_line(0, 63, 63, 0);
        add_line(63, 0, 0, 63);
        add_line(0, 0, 63, 1);
        add_line(0, 0, 1, 63);
        add_line(63, 62, 0, 0);
        add_line(10, 20, 30, 25);
        add_line(30, 25, 10, 20);
        add_line(5, 40, 7, 3);
        add_line(21, 42, 42, 21);
        add_line(42, 21, 21, 42);
        add_line(1, 1, 2, 2);
        add_line(7, 7, 8, 7);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_lines[k])
            send_line(directed_lines[k].req, directed_lines[k].typed, directed_lines[k].dot);

        // Some blocks run back to back on one side or both, to stress the queue.
        for (int blk = 0; blk < RANDOM_BLKS; blk++) begin
            tx_burst = (blk == 1) || (blk == 4);
            rx_burst = (blk == 2) || (blk == 4);
            for (int n = 0; n < BLK_LINES; n++)
                send_line(random_req(), 1'b0, '0);
        end
        i_valid  <= 1'b0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;

        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* line_pixel_stepper.f */
rtl/lps_pkg.sv
rtl/lps_front.sv
rtl/lps_queue.sv
rtl/lps_back.sv
rtl/line_pixel_stepper.sv
sim/tb_line_pixel_stepper.sv
